>>> src/pfs_pkg.sv
// pfs_pkg: shared types and constants of the priority flow scheduler
// depends on nothing; used by the controller, the datapath and the top level
package pfs_pkg;

	// default wait queue depth
	localparam int unsigned DEFAULT_QUEUE_DEPTH = 64;

	// field widths and the sort key layout: priority : arrival : transmit : id
	localparam int unsigned ID_W    = 8;
	localparam int unsigned PRIO_W  = 4;
	localparam int unsigned TIME_W  = 16;
	localparam int unsigned KEY_W   = PRIO_W + 2 * TIME_W + ID_W;
	localparam int unsigned WCNT_W  = 7;

	// command codes of a request
	localparam logic CMD_REQUEST = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	typedef logic [KEY_W-1:0] key_t;

	// controller states
	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	// operation the datapath performs in its execute cycle
	typedef enum logic [2:0] {
		OP_NONE,
		OP_GRANT_NEW,
		OP_QUEUE,
		OP_REJECT,
		OP_POP,
		OP_FREE
	} op_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
		op_t  op;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_release;
		logic id_zero;
		logic queue_empty;
		logic queue_full;
		logic pipe_free;
	} dp_status_t;

endpackage

>>> src/pfs_req_if.sv
// pfs_req_if: request channel of the priority flow scheduler
// valid/ready handshake with the request fields; no dependencies
interface pfs_req_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [7:0]  flow_id;
	logic [3:0]  flow_priority;
	logic [15:0] arrival_tenths;
	logic [15:0] transmit_tenths;

	modport source (
		output valid, command, flow_id, flow_priority, arrival_tenths, transmit_tenths,
		input  ready
	);

	modport sink (
		input  valid, command, flow_id, flow_priority, arrival_tenths, transmit_tenths,
		output ready
	);
endinterface

>>> src/pfs_rsp_if.sv
// pfs_rsp_if: result channel of the priority flow scheduler
// valid/ready handshake with the result fields; no dependencies
interface pfs_rsp_if;
	logic       valid;
	logic       ready;
	logic       granted;
	logic [7:0] grant_id;
	logic       queued;
	logic       rejected;
	logic [6:0] waiting_count;
	logic [7:0] owner_id;

	modport source (
		output valid, granted, grant_id, queued, rejected, waiting_count, owner_id,
		input  ready
	);

	modport sink (
		input  valid, granted, grant_id, queued, rejected, waiting_count, owner_id,
		output ready
	);
endinterface

>>> src/priority_flow_scheduler.sv
// priority_flow_scheduler: top level, arbiter of one shared pipe with a sorted wait queue
// depends on pfs_pkg, pfs_req_if, pfs_rsp_if, pfs_ctrl and pfs_datapath
//
//  channel  dir  carries
//  req      in   command, flow_id, flow_priority, arrival_tenths, transmit_tenths
//  rsp      out  granted, grant_id, queued, rejected, waiting_count, owner_id
//
// each request is latched in the idle state, and the execute state compares its key against
// every queue cell at once, shifts the queue (insert or pop) and loads the result register
// reset clears the owner, the queue count and the handshake state; no clearing pass
// a waiting result does not block acceptance of the next request; its execute cycle
// stalls until the result register is taken
module priority_flow_scheduler #(
	parameter int unsigned QUEUE_DEPTH = pfs_pkg::DEFAULT_QUEUE_DEPTH
) (
	input logic         clk,
	input logic         arst_n,
	pfs_req_if.sink     req,
	pfs_rsp_if.source   rsp
);
	import pfs_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// controller
	pfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// datapath
	pfs_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.command         (req.command),
		.flow_id         (req.flow_id),
		.flow_priority   (req.flow_priority),
		.arrival_tenths  (req.arrival_tenths),
		.transmit_tenths (req.transmit_tenths),
		.cmd             (cmd),
		.status          (status),
		.granted         (rsp.granted),
		.grant_id        (rsp.grant_id),
		.queued          (rsp.queued),
		.rejected        (rsp.rejected),
		.waiting_count   (rsp.waiting_count),
		.owner_id        (rsp.owner_id)
	);

endmodule

>>> src/pfs_ctrl.sv
// pfs_ctrl: controller state machine of the priority flow scheduler
// decides the operation from datapath status; depends on pfs_pkg
module pfs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  pfs_pkg::dp_status_t status,
	output pfs_pkg::ctrl_cmd_t  cmd
);
	import pfs_pkg::*;

	state_t state_q;
	state_t state_next;
	logic   out_valid_q;
	logic   can_exec;
	op_t    op_sel;

	// result register is free or being drained this cycle
	assign can_exec = !out_valid_q || out_ready;

	// operation chosen from the latched request and the queue state
	always_comb begin
		op_sel = OP_NONE;
		if (status.is_release) begin
			op_sel = status.queue_empty ? OP_FREE : OP_POP;
		end else if (!status.id_zero) begin
			priority if (status.pipe_free && status.queue_empty) begin
				op_sel = OP_GRANT_NEW;
			end else if (status.queue_full) begin
				op_sel = OP_REJECT;
			end else begin
				op_sel = OP_QUEUE;
			end
		end
	end

	// next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_next = ST_EXEC;
			end
			ST_EXEC: begin
				if (can_exec) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready = 1'b0;
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		cmd.op   = op_sel;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_EXEC: begin
				cmd.exec = can_exec;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result valid only appears after an execute cycle
	a_valid_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.exec))
		else $error("result valid rose without an execute cycle");

	// never overwrite a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> (!out_valid_q || out_ready))
		else $error("execute while result register is occupied");

	// a full queue never takes another entry
	a_no_queue_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && cmd.op == OP_QUEUE) |-> !status.queue_full)
		else $error("insert into a full queue");

endmodule

>>> src/pfs_datapath.sv
// pfs_datapath: request latch, sorted shift-register wait queue, pipe owner and result register
// driven by pfs_ctrl commands; depends on pfs_pkg
module pfs_datapath #(
	parameter int unsigned QUEUE_DEPTH = pfs_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                command,
	input  logic [7:0]          flow_id,
	input  logic [3:0]          flow_priority,
	input  logic [15:0]         arrival_tenths,
	input  logic [15:0]         transmit_tenths,
	input  pfs_pkg::ctrl_cmd_t  cmd,
	output pfs_pkg::dp_status_t status,
	output logic                granted,
	output logic [7:0]          grant_id,
	output logic                queued,
	output logic                rejected,
	output logic [6:0]          waiting_count,
	output logic [7:0]          owner_id
);
	import pfs_pkg::*;

	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic                command_q;
	key_t                key_q;
	key_t                entries_q [QUEUE_DEPTH];
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_next;
	logic [ID_W-1:0]     owner_q;
	logic [ID_W-1:0]     owner_next;
	logic [ID_W-1:0]     head_id;
	logic [ID_W-1:0]     new_id;
	logic [CNT_W+WCNT_W-1:0] count_ext;
	logic [QUEUE_DEPTH-1:0]  gt;

	assign new_id  = key_q[ID_W-1:0];
	assign head_id = entries_q[0][ID_W-1:0];

	// latch the accepted request as its sort key
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			command_q <= command;
			key_q     <= {flow_priority, arrival_tenths, transmit_tenths, flow_id};
		end
	end

	// status for the controller
	assign status.is_release  = (command_q == CMD_RELEASE);
	assign status.id_zero     = (new_id == '0);
	assign status.queue_empty = (count_q == '0);
	assign status.queue_full  = (count_q >= CNT_W'(QUEUE_DEPTH));
	assign status.pipe_free   = (owner_q == '0);

	// per cell compare: an empty cell counts as worse than any key
	// each cell loads from its left neighbor or the new key on insert, its right neighbor on pop
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		key_t ins_src;
		key_t pop_src;

		assign gt[i] = (CNT_W'(i) >= count_q) || (entries_q[i] > key_q);

		if (i == 0) begin : g_first
			assign ins_src = key_q;
		end else begin : g_rest
			assign ins_src = gt[i-1] ? entries_q[i-1] : key_q;
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign pop_src = entries_q[i];
		end else begin : g_inner
			assign pop_src = entries_q[i+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.exec) begin
				if (cmd.op == OP_QUEUE && gt[i]) begin
					entries_q[i] <= ins_src;
				end else if (cmd.op == OP_POP) begin
					entries_q[i] <= pop_src;
				end
			end
		end
	end

	// next count and owner
	always_comb begin
		count_next = count_q;
		owner_next = owner_q;
		unique case (cmd.op)
			OP_GRANT_NEW: owner_next = new_id;
			OP_QUEUE:     count_next = count_q + 1'b1;
			OP_POP: begin
				count_next = count_q - 1'b1;
				owner_next = head_id;
			end
			OP_FREE:      owner_next = '0;
			default:      count_next = count_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			owner_q <= '0;
		end else if (cmd.exec) begin
			count_q <= count_next;
			owner_q <= owner_next;
		end
	end

	// waiting count is the updated queue count masked to the field width
	assign count_ext = {{WCNT_W{1'b0}}, count_next};

	// result register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			granted       <= (cmd.op == OP_GRANT_NEW) || (cmd.op == OP_POP);
			grant_id      <= (cmd.op == OP_GRANT_NEW) ? new_id :
			                 (cmd.op == OP_POP)       ? head_id : '0;
			queued        <= (cmd.op == OP_QUEUE);
			rejected      <= (cmd.op == OP_REJECT);
			waiting_count <= count_ext[WCNT_W-1:0];
			owner_id      <= owner_next;
		end
	end

	// count stays within the queue
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("wait count beyond queue depth");

	// head of the queue is never worse than the next waiter
	a_sorted_head: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q > CNT_W'(1)) |-> (entries_q[0] <= entries_q[1]))
		else $error("wait queue head out of order");

	// a pop always hands the pipe to a real flow
	a_pop_owner: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && cmd.op == OP_POP) |=> (owner_q != '0))
		else $error("pop left the pipe without an owner");

endmodule
